// ===== design/u8sd_pkg.sv =====
// Shared constants and the scalar range check of the UTF-8 stream decoder.
package u8sd_pkg;

	localparam int CP_W   = 21;
	localparam int DATA_W = 24;
	localparam int USER_W = 3;
	localparam int REP_W  = 3;

	localparam logic [CP_W-1:0] REPL_CP      = 21'h00FFFD;
	localparam logic [CP_W-1:0] MIN_TWO_CP   = 21'h000080;
	localparam logic [CP_W-1:0] MIN_THREE_CP = 21'h000800;
	localparam logic [CP_W-1:0] MIN_FOUR_CP  = 21'h010000;
	localparam logic [CP_W-1:0] MAX_END_CP   = 21'h110000;
	localparam logic [4:0]      SURR_TOP     = 5'b11011;

	localparam logic [7:0] LEAD_TWO   = 8'hC0;
	localparam logic [7:0] LEAD_THREE = 8'hE0;
	localparam logic [7:0] LEAD_FOUR  = 8'hF0;
	localparam logic [7:0] LEAD_BAD   = 8'hF8;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;

	// tuser bit positions
	localparam int U_REPLACED = 0;
	localparam int U_FAULT    = 1;
	localparam int U_DONE     = 2;

	// Check a finished sequence value against its number of continuation bytes.
	function automatic logic value_ok(input logic [CP_W-1:0] v, input logic [1:0] len);
		logic ok;
		begin
			case (len)
				2'd1:    ok = (v >= MIN_TWO_CP);
				2'd2:    ok = (v >= MIN_THREE_CP) && (v[15:11] != SURR_TOP);
				default: ok = (v >= MIN_FOUR_CP) && (v < MAX_END_CP);
			endcase
			return ok;
		end
	endfunction

endpackage

// ===== design/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder: byte input, code point output.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------------
//  s_*     | in        | s_tvalid / s_tready       | tdata[7:0] text_byte, tlast end_of_text
//  m_*     | out       | m_tvalid / m_tready       | tdata[20:0] code_point, tlast last_of_run,
//          |           |                           | tuser replaced, strict_fault, text_done
//  cfg_*   | in        | cfg_we (no wait)          | cfg_wdata strict_mode
//
// One byte is decoded per cycle while the result register can take it. A byte that
// yields n results holds the result register until all n have left, as the result
// register drives one item per cycle while m_tready is high.
// Reset (arst_n low) closes any open sequence, ends discarding and clears strict_mode.
// s_tready is a register: a one-item skid register catches the byte offered while
// the result register is still busy, and s_tready drops only while that is full.
module utf8_stream_decoder_top
	import u8sd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,   // [0] strict_mode
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,     // [7:0] text_byte
	input  logic              s_tlast,     // end_of_text
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,     // [20:0] code_point, [23:21] zero
	output logic [USER_W-1:0] m_tuser,     // [0] replaced, [1] strict_fault, [2] text_done
	output logic              m_tlast      // last_of_run
);

	// decoder state
	logic [CP_W-1:0] part_q;
	logic [1:0]      need_q;
	logic [1:0]      taken_q;
	logic            disc_q;
	logic            strict_q;

	// skid register in front of the decoder
	logic       skid_valid_q;
	logic [7:0] skid_byte_q;
	logic       skid_eot_q;

	// result register: rep_q replacement items, then one tail item (value or fault)
	logic [REP_W-1:0] rep_q;
	logic             tail_q;
	logic [CP_W-1:0]  val_q;
	logic             fault_q;
	logic             done_q;

	logic [7:0] src_byte;
	logic       src_eot;
	logic       src_valid;
	logic       pop;
	logic       one_left;
	logic       load_ok;
	logic       process;
	logic       in_accept;

	// next state and results of the byte under decode
	logic [CP_W-1:0]  n_part;
	logic [1:0]       n_need;
	logic [1:0]       n_taken;
	logic             n_disc;
	logic [REP_W-1:0] r_rep;
	logic             r_tail;
	logic [CP_W-1:0]  r_val;
	logic             r_fault;
	logic             fresh;
	logic [CP_W-1:0]  pv;
	logic [1:0]       taken_inc;
	logic             is_cont;

	// Take the held byte first, else the one on the port.
	assign src_byte  = skid_valid_q ? skid_byte_q : s_tdata;
	assign src_eot   = skid_valid_q ? skid_eot_q : s_tlast;
	assign src_valid = skid_valid_q || s_tvalid;

	assign m_tvalid  = (rep_q != '0) || tail_q;
	assign one_left  = ((rep_q == REP_W'(1)) && !tail_q) || ((rep_q == '0) && tail_q);
	assign pop       = m_tvalid && m_tready;
	// The result register can take a new set when empty or when its final item leaves now.
	assign load_ok   = !m_tvalid || (one_left && m_tready);
	assign process   = src_valid && load_ok;
	assign s_tready  = !skid_valid_q;
	assign in_accept = s_tvalid && s_tready;

	assign is_cont   = ((src_byte & CONT_MASK) == CONT_TAG);
	assign pv        = {part_q[CP_W-7:0], src_byte[5:0]};
	assign taken_inc = taken_q + 2'd1;

	always_comb begin
		n_part  = part_q;
		n_need  = need_q;
		n_taken = taken_q;
		n_disc  = disc_q;
		r_rep   = '0;
		r_tail  = 1'b0;
		r_val   = {{(CP_W-8){1'b0}}, src_byte};
		r_fault = 1'b0;
		fresh   = 1'b1;

		if (disc_q) begin
			// Swallow everything up to the end of the text.
			fresh = 1'b0;
			if (src_eot)
				n_disc = 1'b0;
		end else if (need_q != '0) begin
			if (is_cont) begin
				fresh = 1'b0;
				if (taken_inc == need_q) begin
					n_part  = '0;
					n_need  = '0;
					n_taken = '0;
					if (value_ok(pv, need_q)) begin
						r_tail = 1'b1;
						r_val  = pv;
					end else if (strict_q) begin
						r_tail  = 1'b1;
						r_fault = 1'b1;
						r_val   = '0;
						if (!src_eot)
							n_disc = 1'b1;
					end else begin
						r_rep = REP_W'(need_q) + REP_W'(1);
					end
				end else begin
					n_part  = pv;
					n_taken = taken_inc;
				end
			end else begin
				// Sequence broken: drop it, then decode this byte afresh in lenient mode.
				n_part  = '0;
				n_need  = '0;
				n_taken = '0;
				if (strict_q) begin
					fresh   = 1'b0;
					r_tail  = 1'b1;
					r_fault = 1'b1;
					r_val   = '0;
					if (!src_eot)
						n_disc = 1'b1;
				end else begin
					r_rep = REP_W'(taken_q) + REP_W'(1);
				end
			end
		end

		if (fresh) begin
			if (!src_byte[7]) begin
				r_tail = 1'b1;
			end else if (src_byte < LEAD_TWO || src_byte >= LEAD_BAD) begin
				// Stray continuation byte or impossible lead byte.
				if (strict_q) begin
					r_tail  = 1'b1;
					r_fault = 1'b1;
					r_val   = '0;
					if (!src_eot)
						n_disc = 1'b1;
				end else begin
					r_rep = r_rep + REP_W'(1);
				end
			end else if (src_byte < LEAD_THREE) begin
				n_need  = 2'd1;
				n_taken = '0;
				n_part  = {{(CP_W-5){1'b0}}, src_byte[4:0]};
			end else if (src_byte < LEAD_FOUR) begin
				n_need  = 2'd2;
				n_taken = '0;
				n_part  = {{(CP_W-4){1'b0}}, src_byte[3:0]};
			end else begin
				n_need  = 2'd3;
				n_taken = '0;
				n_part  = {{(CP_W-3){1'b0}}, src_byte[2:0]};
			end
		end

		if (src_eot) begin
			// Flush a sequence left open at the end of the text.
			if (n_need != '0 && !n_disc) begin
				if (strict_q) begin
					r_tail  = 1'b1;
					r_fault = 1'b1;
					r_val   = '0;
				end else begin
					r_rep = r_rep + REP_W'(n_taken) + REP_W'(1);
				end
			end
			n_part  = '0;
			n_need  = '0;
			n_taken = '0;
			n_disc  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q       <= '0;
			need_q       <= '0;
			taken_q      <= '0;
			disc_q       <= 1'b0;
			strict_q     <= 1'b0;
			skid_valid_q <= 1'b0;
			rep_q        <= '0;
			tail_q       <= 1'b0;
		end else begin
			if (cfg_we)
				strict_q <= cfg_wdata;

			// Hold the port byte when the decoder cannot take it; release once decoded.
			if (in_accept && !load_ok)
				skid_valid_q <= 1'b1;
			else if (skid_valid_q && process)
				skid_valid_q <= 1'b0;

			if (process) begin
				part_q  <= n_part;
				need_q  <= n_need;
				taken_q <= n_taken;
				disc_q  <= n_disc;
				rep_q   <= r_rep;
				tail_q  <= r_tail;
			end else if (pop) begin
				// Replacement items go out first, the tail item last.
				if (rep_q != '0)
					rep_q <= rep_q - REP_W'(1);
				else
					tail_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept && !load_ok) begin
			skid_byte_q <= s_tdata;
			skid_eot_q  <= s_tlast;
		end
		if (process) begin
			val_q   <= r_val;
			fault_q <= r_fault;
			done_q  <= src_eot;
		end
	end

	assign m_tdata = {{(DATA_W-CP_W){1'b0}}, (rep_q != '0) ? REPL_CP : val_q};
	assign m_tuser[U_REPLACED] = (rep_q != '0);
	assign m_tuser[U_FAULT]    = (rep_q == '0) && fault_q;
	assign m_tuser[U_DONE]     = done_q;
	assign m_tlast = one_left;

endmodule

// ===== design/u8sd_checker.sv =====
// Port-level checks of the UTF-8 stream decoder and their binding.
module u8sd_checker
	import u8sd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic [USER_W-1:0] m_tuser,
	input logic              m_tlast
);

	// A pending result stays offered until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// A strict fault is a lone zero result, never a replacement.
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[U_FAULT] |-> m_tlast && m_tdata == '0 && !m_tuser[U_REPLACED])
		else $error("malformed strict fault result");

	// A replaced item always carries U+FFFD.
	a_repl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[U_REPLACED] |-> m_tdata[CP_W-1:0] == REPL_CP)
		else $error("replacement item without U+FFFD");

	// A decoded scalar is in range and no surrogate.
	a_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[U_REPLACED] && !m_tuser[U_FAULT] |->
			m_tdata[CP_W-1:0] < MAX_END_CP && m_tdata[DATA_W-1:CP_W] == '0 &&
			!(m_tdata[CP_W-1:16] == '0 && m_tdata[15:11] == SURR_TOP))
		else $error("decoded value is not a Unicode scalar");

	// Input ready only drops right after a byte was taken.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("input ready dropped without a byte taken");

endmodule

bind utf8_stream_decoder_top u8sd_checker u_chk (.*);

// ===== verif/utf8_decoder_checker.sv =====
// Checker for the UTF-8 stream decoder: predicts every result and compares it as it leaves.
module utf8_decoder_checker
	import u8sd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,
	input  logic [USER_W-1:0] m_tuser,
	input  logic              m_tlast,
	output int                results_waiting,
	output int                decoded_bytes,
	output int                results_checked,
	output int                replacements_seen,
	output int                faults_seen,
	output int                fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int              MAX_RUN    = 4;
	localparam logic [CP_W-1:0] SURR_MASK  = 21'h00F800;
	localparam logic [CP_W-1:0] SURR_BASE  = 21'h00D800;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            replaced;
		logic            strict_fault;
		logic            last_of_run;
		logic            text_done;
	} scalar_out_t;

	scalar_out_t     scalars_due[$];
	scalar_out_t     byte_run[$];

	logic [CP_W-1:0] acc_value;
	logic [1:0]      conts_needed;
	logic [1:0]      conts_taken;
	logic            swallowing;
	logic            strict_on;
	int              live_count;
	int              checked_count;
	int              repl_count;
	int              fault_count;
	int              errors;

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		errors++;
		$display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
			$realtime, what, want, got);
	endtask

	function automatic void close_seq();
		acc_value    = '0;
		conts_needed = '0;
		conts_taken  = '0;
	endfunction

	function automatic void emit_scalar(input logic [CP_W-1:0] cp, input logic repl,
			input logic fault, input logic eot);
		scalar_out_t r;
		r.code_point   = cp;
		r.replaced     = repl;
		r.strict_fault = fault;
		r.last_of_run  = 1'b0;
		r.text_done    = eot;
		if (byte_run.size() < MAX_RUN)
			byte_run = {byte_run, r};
	endfunction

	// Drop the open sequence; true when strict mode aborted the text.
	function automatic logic abandon_seq(input int count, input logic eot);
		int k;
		close_seq();
		if (strict_on) begin
			emit_scalar('0, 1'b0, 1'b1, eot);
			if (!eot)
				swallowing = 1'b1;
			return 1'b1;
		end
		for (k = 0; k < count; k++)
			emit_scalar(REPL_CP, 1'b1, 1'b0, eot);
		return 1'b0;
	endfunction

	function automatic logic scalar_legal(input logic [CP_W-1:0] v, input logic [1:0] len);
		if (len == 2'd1)
			return v >= MIN_TWO_CP;
		if (len == 2'd2)
			return (v >= MIN_THREE_CP) && ((v & SURR_MASK) != SURR_BASE);
		return (v >= MIN_FOUR_CP) && (v < MAX_END_CP);
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic eot);
		logic        fresh;
		byte_run.delete();
		fresh = 1'b1;
		if (swallowing) begin
			if (eot)
				swallowing = 1'b0;
			return;
		end
		live_count++;
		if (conts_needed != 2'd0) begin
			if ((b & CONT_MASK) == CONT_TAG) begin
				fresh       = 1'b0;
				acc_value   = {acc_value[CP_W-7:0], b[5:0]};
				conts_taken = conts_taken + 2'd1;
				if (conts_taken >= conts_needed) begin
					if (scalar_legal(acc_value, conts_needed)) begin
						emit_scalar(acc_value, 1'b0, 1'b0, eot);
						close_seq();
					end else begin
						void'(abandon_seq(int'(conts_needed) + 1, eot));
					end
				end
			end else if (abandon_seq(int'(conts_taken) + 1, eot)) begin
				fresh = 1'b0;
			end
		end
		if (fresh) begin
			if (b < CONT_TAG) begin
				emit_scalar({13'd0, b}, 1'b0, 1'b0, eot);
			end else if (b < LEAD_TWO) begin
				void'(abandon_seq(1, eot));
			end else if (b < LEAD_THREE) begin
				conts_needed = 2'd1;
				acc_value    = {16'd0, b[4:0]};
			end else if (b < LEAD_FOUR) begin
				conts_needed = 2'd2;
				acc_value    = {17'd0, b[3:0]};
			end else if (b < LEAD_BAD) begin
				conts_needed = 2'd3;
				acc_value    = {18'd0, b[2:0]};
			end else begin
				void'(abandon_seq(1, eot));
			end
		end
		// flush a sequence cut off by the end of the text
		if (eot) begin
			if (conts_needed != 2'd0 && !swallowing)
				void'(abandon_seq(int'(conts_taken) + 1, eot));
			close_seq();
			swallowing = 1'b0;
		end
		if (byte_run.size() != 0)
			byte_run[byte_run.size() - 1].last_of_run = 1'b1;
		scalars_due = {scalars_due, byte_run};
	endfunction

	task automatic check_result();
		scalar_out_t want;
		if (scalars_due.size() == 0) begin
			report_mismatch("result with nothing expected", '0, 32'(m_tdata));
			return;
		end
		want = scalars_due.pop_front();
		checked_count++;
		if (m_tuser[U_REPLACED])
			repl_count++;
		if (m_tuser[U_FAULT])
			fault_count++;
		if (m_tdata[CP_W-1:0] != want.code_point)
			report_mismatch("code_point", 32'(want.code_point), 32'(m_tdata[CP_W-1:0]));
		if (m_tdata[DATA_W-1:CP_W] != '0)
			report_mismatch("tdata padding", '0, 32'(m_tdata[DATA_W-1:CP_W]));
		if (m_tuser[U_REPLACED] != want.replaced)
			report_mismatch("replaced", 32'(want.replaced), 32'(m_tuser[U_REPLACED]));
		if (m_tuser[U_FAULT] != want.strict_fault)
			report_mismatch("strict_fault", 32'(want.strict_fault), 32'(m_tuser[U_FAULT]));
		if (m_tuser[U_DONE] != want.text_done)
			report_mismatch("text_done", 32'(want.text_done), 32'(m_tuser[U_DONE]));
		if (m_tlast != want.last_of_run)
			report_mismatch("last_of_run", 32'(want.last_of_run), 32'(m_tlast));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_seq();
			swallowing = 1'b0;
			strict_on  = 1'b0;
			scalars_due.delete();
			live_count    = 0;
			checked_count = 0;
			repl_count    = 0;
			fault_count   = 0;
			errors        = 0;
			results_waiting   <= 0;
			decoded_bytes     <= 0;
			results_checked   <= 0;
			replacements_seen <= 0;
			faults_seen       <= 0;
			fail_count        <= 0;
		end else begin
			if (cfg_we)
				strict_on = cfg_wdata;
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_result();
			results_waiting   <= scalars_due.size();
			decoded_bytes     <= live_count;
			results_checked   <= checked_count;
			replacements_seen <= repl_count;
			faults_seen       <= fault_count;
			fail_count        <= errors;
		end
	end

endmodule

// ===== verif/tb.sv =====
// Testbench top of the UTF-8 stream decoder: clock, reset, byte stimulus and verdict.
module tb;
	import u8sd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles to let the block settle after the last expected result: a byte that
	// yields nothing may still sit in the skid register.
	localparam int SETTLE_CYCLES = 8;
	// Bound on the run, with a wide margin over the slowest correct run and its drains.
	localparam int CYCLE_LIMIT   = 500_000;
	localparam int TOTAL_ITEMS   = 430;
	localparam int TEXTS_PER_SET = 6;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic [USER_W-1:0] m_tuser;
	logic              m_tlast;

	int results_waiting;
	int decoded_bytes;
	int results_checked;
	int replacements_seen;
	int faults_seen;
	int fail_count;

	int cycle_count;
	int sent_items;
	int text_count;
	int mode_writes;
	logic tx_calm;
	logic rx_calm;
	int   rx_hold;
	logic strict_now;

	logic [7:0] text_q[$];

	// Directed bytes: bit 8 is end_of_text, bits 7:0 the byte.
	// Lenient: 00 and 7F, U+7FF, overlong C1 BF, surrogate ED A0 80, F4 90 80 80 above
	// the top of the range (four replacements), U+10000, a stray continuation, FF,
	// E2 82 broken by 'A', and a four-byte lead cut off by the end of the text.
	logic [8:0] lenient_seq[$] = '{9'h000, 9'h07F, 9'h0DF, 9'h0BF, 9'h0C1, 9'h0BF,
		9'h0ED, 9'h0A0, 9'h080, 9'h0F4, 9'h090, 9'h080, 9'h080, 9'h0F0, 9'h090,
		9'h080, 9'h080, 9'h080, 9'h0FF, 9'h0E2, 9'h082, 9'h041, 9'h1F0};

	utf8_stream_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	utf8_decoder_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tlast           (s_tlast),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tuser           (m_tuser),
		.m_tlast           (m_tlast),
		.results_waiting   (results_waiting),
		.decoded_bytes     (decoded_bytes),
		.results_checked   (results_checked),
		.replacements_seen (replacements_seen),
		.faults_seen       (faults_seen),
		.fail_count        (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stop a hung run: nothing here waits on the block without this behind it.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout: run still busy after %0d cycles", CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	// Receiver: when not calm, a taken item may drop tready for a drawn number of cycles.
	// Calm stretches take every item at once; flip between the two now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold  <= 0;
			rx_calm  <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			if ($urandom_range(0, 47) == 0)
				rx_calm <= !rx_calm;
			if (!rx_calm && $urandom_range(0, 1) != 0) begin
				m_tready <= 1'b0;
				rx_hold  <= $urandom_range(1, 16);
			end
		end else if (!m_tready) begin
			if (rx_hold <= 1)
				m_tready <= 1'b1;
			rx_hold <= rx_hold - 1;
		end
	end

	// Offer one item after a drawn gap and hold it until taken. tvalid stays high
	// on return, so a back-to-back item never lowers and raises it in one step.
	task automatic send_item(input logic [7:0] value, input logic eot);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= eot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_items++;
	endtask

	// Hold the sender until every expected result has come, then let the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write strict_mode; only ever called with the block idle.
	task automatic set_strict(input logic mode);
		cfg_we     <= 1'b1;
		cfg_wdata  <= mode;
		strict_now  = mode;
		mode_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_seq(input logic [8:0] seq[$]);
		foreach (seq[i])
			send_item(seq[i][7:0], seq[i][8]);
	endtask

	// Append one byte to the text under construction.
	function automatic void put_byte(input logic [7:0] b);
		text_q = {text_q, b};
	endfunction

	// Append cp encoded in len bytes; a len beyond what cp needs gives an overlong form.
	function automatic void put_utf8(input logic [20:0] cp, input int len);
		case (len)
			1: put_byte({1'b0, cp[6:0]});
			2: begin
				put_byte({3'b110, cp[10:6]});
				put_byte({2'b10, cp[5:0]});
			end
			3: begin
				put_byte({4'b1110, cp[15:12]});
				put_byte({2'b10, cp[11:6]});
				put_byte({2'b10, cp[5:0]});
			end
			default: begin
				put_byte({5'b11110, cp[20:18]});
				put_byte({2'b10, cp[17:12]});
				put_byte({2'b10, cp[11:6]});
				put_byte({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// Append one character: well formed when tidy, else drawn from noise and faults too.
	function automatic void add_char(input logic tidy);
		int          pick;
		int          len;
		logic [20:0] cp;
		pick = tidy ? $urandom_range(0, 3) : $urandom_range(0, 9);
		case (pick)
			0: put_utf8(21'($urandom_range(0, 'h7F)), 1);
			1: put_utf8(21'($urandom_range('h80, 'h7FF)), 2);
			2: begin
				cp = 21'($urandom_range('h800, 'hFFFF));
				// move a surrogate up into F800-FFFF
				if (cp[15:11] == 5'b11011)
					cp[13] = 1'b1;
				put_utf8(cp, 3);
			end
			3: put_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4);
			4: put_byte(8'($urandom_range(0, 255)));
			5: begin
				len = $urandom_range(2, 4);
				if (len == 2)
					cp = 21'($urandom_range(0, 'h7F));
				else if (len == 3)
					cp = 21'($urandom_range(0, 'h7FF));
				else
					cp = 21'($urandom_range(0, 'hFFFF));
				put_utf8(cp, len);
			end
			6: put_utf8(21'($urandom_range('hD800, 'hDFFF)), 3);
			7: put_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4);
			8: begin
				// sequence cut short by whatever follows
				len = $urandom_range(2, 4);
				put_utf8(21'($urandom_range(0, 'h1FFFFF)), len);
				repeat ($urandom_range(1, len - 1))
					void'(text_q.pop_back());
			end
			default: begin
				if ($urandom_range(0, 1) != 0)
					put_byte(8'($urandom_range('h80, 'hBF)));
				else
					put_byte(8'($urandom_range('hF8, 'hFF)));
			end
		endcase
	endfunction

	// Build and send one text; its last byte carries end_of_text.
	task automatic send_text();
		logic tidy;
		int   chars;
		tidy    = ($urandom_range(0, 3) != 0);
		tx_calm = ($urandom_range(0, 3) == 0);
		chars   = $urandom_range(1, 8);
		text_q.delete();
		repeat (chars)
			add_char(tidy);
		foreach (text_q[i])
			send_item(text_q[i], i == text_q.size() - 1);
		text_count++;
	endtask

	initial begin
		// drive every input to a known value before the first edge
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		tx_calm   = 1'b0;
		sent_items  = 0;
		text_count  = 0;
		mode_writes = 0;
		strict_now  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lenient directed texts: replacements, flushes and the extremes of the range.
		set_strict(1'b0);
		send_seq(lenient_seq);
		drain();

		// Strict: a broken two-byte sequence faults, then the rest is swallowed. Clear
		// strict mode half way: the discard must still run on to the end of the text.
		set_strict(1'b1);
		send_seq('{9'h0C3, 9'h041, 9'h042});
		drain();
		set_strict(1'b0);
		send_seq('{9'h043, 9'h144});
		drain();

		// Strict fault on the end_of_text byte itself: no discard follows.
		set_strict(1'b1);
		send_seq('{9'h1FF, 9'h141});
		drain();

		// Random texts in sets, alternating the mode between sets. Each switch also
		// holds the sender until the block has caught up completely.
		while (sent_items < TOTAL_ITEMS) begin
			if (text_count % TEXTS_PER_SET == 0) begin
				drain();
				set_strict(!strict_now);
			end
			send_text();
		end
		drain();

		$display("summary: %0d bytes sent in %0d random texts plus directed ones",
			sent_items, text_count);
		$display("summary: %0d decoded, %0d results checked, %0d replacements,",
			decoded_bytes, results_checked, replacements_seen);
		$display("summary: %0d strict faults, %0d mode writes",
			faults_seen, mode_writes);
		if (fail_count == 0 && results_waiting == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
